@@ hw/rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros shared by the RTL
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge, disabled while reset is low.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Check that a condition never holds on a rising clock edge outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error(msg);

`endif

@@ hw/rtl/hill_pkg.sv @@
// ----------------------------------------------------------------------------
// hill_pkg
// Types, constants and modulo-26 helpers for the 2x2 Hill cipher core.
// ----------------------------------------------------------------------------
package hill_pkg;

    localparam int LETTER_W = 5;
    localparam int MODULUS  = 26;
    localparam int MOD_SQ   = MODULUS * MODULUS;

    localparam logic [LETTER_W-1:0] PAD_LETTER = 5'd25;

    // output FIFO depth; keep it an even power of two, the pointers wrap freely
    localparam int FIFO_DEPTH = 16;

    // floor(x * RECIP_26 >> RECIP_SHIFT) is floor(x / 26) or one less for x < 2048
    localparam int RECIP_26    = 315;
    localparam int RECIP_SHIFT = 13;

    typedef enum logic [2:0] {
        REG_KEY_R0C0 = 3'd0,
        REG_KEY_R0C1 = 3'd1,
        REG_KEY_R1C0 = 3'd2,
        REG_KEY_R1C1 = 3'd3,
        REG_MODE     = 3'd4
    } t_reg_idx;

    typedef struct packed {
        logic [LETTER_W-1:0] p0;
        logic [LETTER_W-1:0] p1;
        logic                last;
    } t_pair;

    typedef struct packed {
        logic [LETTER_W-1:0] m00;
        logic [LETTER_W-1:0] m01;
        logic [LETTER_W-1:0] m10;
        logic [LETTER_W-1:0] m11;
    } t_mat;

    typedef struct packed {
        logic [LETTER_W-1:0] letter;
        logic                last;
        logic                err;
    } t_entry;

    // Reduce a 5-bit value to 0..25.
    function automatic logic [LETTER_W-1:0] red26(input logic [LETTER_W-1:0] v);
        return (v >= 5'd26) ? 5'(v - 5'd26) : v;
    endfunction

    // Reduce an 11-bit value modulo 26 by reciprocal multiply and one correction.
    function automatic logic [LETTER_W-1:0] mod26(input logic [10:0] x);
        logic [19:0] prod;
        logic [6:0]  q;
        logic [10:0] r;
        prod = 20'(x) * 20'(RECIP_26);
        q    = prod[19:RECIP_SHIFT];
        r    = x - 11'(11'(q) * 11'(MODULUS));
        if (r >= 11'(MODULUS)) begin
            r = r - 11'(MODULUS);
        end
        return r[LETTER_W-1:0];
    endfunction

    // Product of two values in 0..25, reduced modulo 26.
    function automatic logic [LETTER_W-1:0] mulmod26(input logic [LETTER_W-1:0] a,
                                                     input logic [LETTER_W-1:0] b);
        return mod26(11'(10'(a) * 10'(b)));
    endfunction

    // Additive inverse modulo 26 of a value in 0..25.
    function automatic logic [LETTER_W-1:0] neg26(input logic [LETTER_W-1:0] v);
        return (v == '0) ? '0 : 5'(5'(MODULUS) - v);
    endfunction

    // Multiplicative inverse modulo 26; zero where none exists.
    function automatic logic [LETTER_W-1:0] inv26(input logic [LETTER_W-1:0] v);
        logic [LETTER_W-1:0] r;
        case (v)
            5'd1:    r = 5'd1;
            5'd3:    r = 5'd9;
            5'd5:    r = 5'd21;
            5'd7:    r = 5'd15;
            5'd9:    r = 5'd3;
            5'd11:   r = 5'd19;
            5'd15:   r = 5'd7;
            5'd17:   r = 5'd23;
            5'd19:   r = 5'd11;
            5'd21:   r = 5'd5;
            5'd23:   r = 5'd17;
            5'd25:   r = 5'd25;
            default: r = 5'd0;
        endcase
        return r;
    endfunction

endpackage

@@ hw/rtl/hill_cipher_2x2_mod26_core.sv @@
// ----------------------------------------------------------------------------
// hill_cipher_2x2_mod26_core
// 2x2 Hill cipher over letters 0..25, encrypt with the key or decrypt with
// its inverse modulo 26.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one letter per request (tdata[4:0]), tlast marks the last
//   letter of a message. Letters are paired; the second letter of a pair, or
//   a lone last letter padded with 'z', releases two letters on m_axis
//   (tdata[4:0] letter, tlast on the final letter, tuser = key error).
//   The APB port holds the four key entries and the decrypt mode bit at
//   byte addresses 0, 4, 8, 12 and 16; registers are read back on prdata.
// Pipeline and throughput:
//   A completed pair runs through five register stages (pairing, key
//   products, determinant inverse, effective matrix, letter products) and
//   lands in the output FIFO, from which its first letter is offered on
//   m_axis. One letter is taken per cycle while s_axis_tready is high,
//   bounded by m_axis draining one letter per cycle.
// Stall and reset:
//   The output FIFO (FIFO_DEPTH entries) holds results while m_axis is
//   stalled; s_axis_tready drops once the FIFO plus pairs in flight leave
//   fewer than two free slots. Reset restores the identity key in encrypt
//   mode, drops any held letter and empties the FIFO.
// ----------------------------------------------------------------------------
module hill_cipher_2x2_mod26_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // letters in
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [4:0] letter_in, [7:5] zero
    input  logic        s_axis_tlast,   // last_in
    // letters out
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [4:0] letter_out, [7:5] zero
    output logic        m_axis_tlast,   // last_out
    output logic        m_axis_tuser    // key_error
);

    `include "assert_macros.svh"

    localparam int PTR_W = $clog2(hill_pkg::FIFO_DEPTH);
    localparam int CNT_W = $clog2(hill_pkg::FIFO_DEPTH + 1);

    // ---------------------------------------------------------------- config
    logic [4:0] r_key00, r_key01, r_key10, r_key11;
    logic       r_mode;
    logic       cfg_wr;
    hill_pkg::t_reg_idx cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite & pready;
    assign cfg_idx = hill_pkg::t_reg_idx'(paddr[4:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key00 <= 5'd1;
            r_key01 <= 5'd0;
            r_key10 <= 5'd0;
            r_key11 <= 5'd1;
            r_mode  <= 1'b0;
        end else if (cfg_wr) begin
            case (cfg_idx)
                hill_pkg::REG_KEY_R0C0: r_key00 <= pwdata[4:0];
                hill_pkg::REG_KEY_R0C1: r_key01 <= pwdata[4:0];
                hill_pkg::REG_KEY_R1C0: r_key10 <= pwdata[4:0];
                hill_pkg::REG_KEY_R1C1: r_key11 <= pwdata[4:0];
                hill_pkg::REG_MODE:     r_mode  <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            hill_pkg::REG_KEY_R0C0: prdata = {27'd0, r_key00};
            hill_pkg::REG_KEY_R0C1: prdata = {27'd0, r_key01};
            hill_pkg::REG_KEY_R1C0: prdata = {27'd0, r_key10};
            hill_pkg::REG_KEY_R1C1: prdata = {27'd0, r_key11};
            hill_pkg::REG_MODE:     prdata = {31'd0, r_mode};
            default:                prdata = 32'd0;
        endcase
    end

    // --------------------------------------------------------------- pairing
    logic       in_acc;
    logic       pair_acc;
    logic [4:0] in_letter;
    logic       r_holding;
    logic [4:0] r_held;

    assign in_acc    = s_axis_tvalid & s_axis_tready;
    assign pair_acc  = in_acc & (r_holding | s_axis_tlast);
    assign in_letter = hill_pkg::red26(s_axis_tdata[4:0]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_holding <= 1'b0;
        end else if (in_acc) begin
            r_holding <= !r_holding && !s_axis_tlast;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && !r_holding) begin
            r_held <= in_letter;
        end
    end

    // -------------------------------------------------------------- pipeline
    logic                r_va, r_vb, r_vc, r_vd, r_ve;
    hill_pkg::t_pair     r_a_pair, r_b_pair, r_c_pair, r_d_pair;
    hill_pkg::t_mat      r_b_key, r_c_key, r_d_mat;
    logic [9:0]          r_b_ad, r_b_bc;
    logic                r_b_mode, r_c_mode;
    logic [4:0]          r_c_dinv;
    logic                r_c_err, r_d_err, r_e_err;
    logic [10:0]         r_e_s0, r_e_s1;
    logic                r_e_last;
    logic [4:0]          c_det;
    logic [4:0]          c_dinv;
    hill_pkg::t_mat      d_mat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
            r_vc <= 1'b0;
            r_vd <= 1'b0;
            r_ve <= 1'b0;
        end else begin
            r_va <= pair_acc;
            r_vb <= r_va;
            r_vc <= r_vb;
            r_vd <= r_vc;
            r_ve <= r_vd;
        end
    end

    // stage A: complete pair, pad a lone last letter
    always_ff @(posedge i_clk) begin
        r_a_pair.p0   <= r_holding ? r_held : in_letter;
        r_a_pair.p1   <= r_holding ? in_letter : hill_pkg::PAD_LETTER;
        r_a_pair.last <= s_axis_tlast;
    end

    // stage B: sample the key, form the determinant products
    always_ff @(posedge i_clk) begin
        r_b_pair    <= r_a_pair;
        r_b_key.m00 <= hill_pkg::red26(r_key00);
        r_b_key.m01 <= hill_pkg::red26(r_key01);
        r_b_key.m10 <= hill_pkg::red26(r_key10);
        r_b_key.m11 <= hill_pkg::red26(r_key11);
        r_b_ad      <= 10'(hill_pkg::red26(r_key00)) * 10'(hill_pkg::red26(r_key11));
        r_b_bc      <= 10'(hill_pkg::red26(r_key01)) * 10'(hill_pkg::red26(r_key10));
        r_b_mode    <= r_mode;
    end

    // stage C: determinant modulo 26 and its inverse
    assign c_det  = hill_pkg::mod26(11'(r_b_ad) + 11'(hill_pkg::MOD_SQ) - 11'(r_b_bc));
    assign c_dinv = hill_pkg::inv26(c_det);

    always_ff @(posedge i_clk) begin
        r_c_pair <= r_b_pair;
        r_c_key  <= r_b_key;
        r_c_dinv <= c_dinv;
        r_c_err  <= r_b_mode && (c_dinv == '0);
        r_c_mode <= r_b_mode;
    end

    // stage D: in decrypt mode the key is the adjugate scaled by the determinant inverse, else the key passes through
    always_comb begin
        if (r_c_mode) begin
            d_mat.m00 = hill_pkg::mulmod26(r_c_key.m11, r_c_dinv);
            d_mat.m01 = hill_pkg::mulmod26(hill_pkg::neg26(r_c_key.m01), r_c_dinv);
            d_mat.m10 = hill_pkg::mulmod26(hill_pkg::neg26(r_c_key.m10), r_c_dinv);
            d_mat.m11 = hill_pkg::mulmod26(r_c_key.m00, r_c_dinv);
        end else begin
            d_mat = r_c_key;
        end
    end

    always_ff @(posedge i_clk) begin
        r_d_pair <= r_c_pair;
        r_d_mat  <= d_mat;
        r_d_err  <= r_c_err;
    end

    // stage E: matrix times pair, unreduced
    always_ff @(posedge i_clk) begin
        r_e_s0   <= 11'(10'(r_d_mat.m00) * 10'(r_d_pair.p0))
                  + 11'(10'(r_d_mat.m01) * 10'(r_d_pair.p1));
        r_e_s1   <= 11'(10'(r_d_mat.m10) * 10'(r_d_pair.p0))
                  + 11'(10'(r_d_mat.m11) * 10'(r_d_pair.p1));
        r_e_last <= r_d_pair.last;
        r_e_err  <= r_d_err;
    end

    // ------------------------------------------------------------ output FIFO
    hill_pkg::t_entry   r_fifo [hill_pkg::FIFO_DEPTH];
    hill_pkg::t_entry   push0, push1;
    logic [PTR_W-1:0]   r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0]   r_count, r_used;
    logic [CNT_W-1:0]   n_count, n_used;
    logic               pop;

    always_comb begin
        push0.letter = r_e_err ? '0 : hill_pkg::mod26(r_e_s0);
        push0.last   = 1'b0;
        push0.err    = r_e_err;
        push1.letter = r_e_err ? '0 : hill_pkg::mod26(r_e_s1);
        push1.last   = r_e_last;
        push1.err    = r_e_err;
    end

    always_ff @(posedge i_clk) begin
        if (r_ve) begin
            r_fifo[r_wr_ptr]                <= push0;
            r_fifo[r_wr_ptr + PTR_W'(1)]    <= push1;
        end
    end

    assign pop = m_axis_tvalid & m_axis_tready;

    // used counts stored entries plus two slots reserved for each pair in flight
    always_comb begin
        n_count = r_count + (r_ve ? CNT_W'(2) : '0) - (pop ? CNT_W'(1) : '0);
        n_used  = r_used + (pair_acc ? CNT_W'(2) : '0) - (pop ? CNT_W'(1) : '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
            r_used   <= '0;
        end else begin
            if (r_ve) begin
                r_wr_ptr <= r_wr_ptr + PTR_W'(2);
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + PTR_W'(1);
            end
            r_count <= n_count;
            r_used  <= n_used;
        end
    end

    assign s_axis_tready = (r_used <= CNT_W'(hill_pkg::FIFO_DEPTH - 2));
    assign m_axis_tvalid = (r_count != '0);
    assign m_axis_tdata  = {3'd0, r_fifo[r_rd_ptr].letter};
    assign m_axis_tlast  = r_fifo[r_rd_ptr].last;
    assign m_axis_tuser  = r_fifo[r_rd_ptr].err;

    // ------------------------------------------------------------- assertions
    logic [2:0]       inflight;
    logic [CNT_W-1:0] reserved;

    assign inflight = 3'(r_va) + 3'(r_vb) + 3'(r_vc) + 3'(r_vd) + 3'(r_ve);
    assign reserved = CNT_W'({inflight, 1'b0});

    `ASSERT_CLK(a_credit_balance, i_clk, i_rst_n,
        r_used == r_count + reserved, "credit count disagrees with FIFO and pipeline")
    `ASSERT_CLK(a_push_room, i_clk, i_rst_n,
        r_ve |-> r_count <= CNT_W'(hill_pkg::FIFO_DEPTH - 2), "pair pushed into a full FIFO")
    `ASSERT_NEVER(a_no_overbook, i_clk, i_rst_n,
        r_used > CNT_W'(hill_pkg::FIFO_DEPTH), "more FIFO slots reserved than exist")
    `ASSERT_CLK(a_last_clears_hold, i_clk, i_rst_n,
        in_acc && s_axis_tlast |=> !r_holding, "letter still held after a last letter")

endmodule
